>>> src/tmrf_pkg.sv
// ----------------------------------------------------------------------------
// tmrf_pkg
// Shared types and constants of the terminal mode register file: request and
// result payloads, operation and status codes, mode numbers and flag layout.
// ----------------------------------------------------------------------------
package tmrf_pkg;

  localparam int unsigned FLAG_W  = 15;
  localparam int unsigned FIDX_W  = 4;
  localparam int unsigned TRK_W   = 3;
  localparam int unsigned MODE_W  = 16;

  typedef enum logic [1:0] {
    OP_SET_ANSI    = 2'd0,
    OP_SET_PRIVATE = 2'd1,
    OP_QRY_ANSI    = 2'd2,
    OP_QRY_PRIVATE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STAT_UNKNOWN = 2'd0,
    STAT_SET     = 2'd1,
    STAT_RESET   = 2'd2
  } status_t;

  typedef enum logic [TRK_W-1:0] {
    TRK_OFF  = 3'd0,
    TRK_9    = 3'd1,
    TRK_1000 = 3'd2,
    TRK_1002 = 3'd3,
    TRK_1003 = 3'd4
  } trk_t;

  // flag bit positions
  localparam logic [FIDX_W-1:0] FLAG_INSERT  = 4'd0;
  localparam logic [FIDX_W-1:0] FLAG_NEWLINE = 4'd1;
  localparam logic [FIDX_W-1:0] FLAG_APPKEYS = 4'd2;
  localparam logic [FIDX_W-1:0] FLAG_ORIGIN  = 4'd3;
  localparam logic [FIDX_W-1:0] FLAG_WRAP    = 4'd4;
  localparam logic [FIDX_W-1:0] FLAG_BLINK   = 4'd5;
  localparam logic [FIDX_W-1:0] FLAG_CURSOR  = 4'd6;
  localparam logic [FIDX_W-1:0] FLAG_ALTSCR  = 4'd7;
  localparam logic [FIDX_W-1:0] FLAG_FOCUS   = 4'd8;
  localparam logic [FIDX_W-1:0] FLAG_UTF8    = 4'd9;
  localparam logic [FIDX_W-1:0] FLAG_SGR     = 4'd10;
  localparam logic [FIDX_W-1:0] FLAG_ASCROLL = 4'd11;
  localparam logic [FIDX_W-1:0] FLAG_URXVT   = 4'd12;
  localparam logic [FIDX_W-1:0] FLAG_PIXELS  = 4'd13;
  localparam logic [FIDX_W-1:0] FLAG_PASTE   = 4'd14;

  localparam logic [FLAG_W-1:0] ENCODING_MASK = 15'h3600;

  // mode numbers
  localparam logic [MODE_W-1:0] MODE_INSERT   = 16'd4;
  localparam logic [MODE_W-1:0] MODE_NEWLINE  = 16'd20;
  localparam logic [MODE_W-1:0] MODE_APPKEYS  = 16'd1;
  localparam logic [MODE_W-1:0] MODE_ORIGIN   = 16'd6;
  localparam logic [MODE_W-1:0] MODE_WRAP     = 16'd7;
  localparam logic [MODE_W-1:0] MODE_TRK_X10  = 16'd9;
  localparam logic [MODE_W-1:0] MODE_BLINK    = 16'd12;
  localparam logic [MODE_W-1:0] MODE_CURSOR   = 16'd25;
  localparam logic [MODE_W-1:0] MODE_ALT47    = 16'd47;
  localparam logic [MODE_W-1:0] MODE_TRK_1000 = 16'd1000;
  localparam logic [MODE_W-1:0] MODE_TRK_1002 = 16'd1002;
  localparam logic [MODE_W-1:0] MODE_TRK_1003 = 16'd1003;
  localparam logic [MODE_W-1:0] MODE_FOCUS    = 16'd1004;
  localparam logic [MODE_W-1:0] MODE_UTF8     = 16'd1005;
  localparam logic [MODE_W-1:0] MODE_SGR      = 16'd1006;
  localparam logic [MODE_W-1:0] MODE_ASCROLL  = 16'd1007;
  localparam logic [MODE_W-1:0] MODE_URXVT    = 16'd1015;
  localparam logic [MODE_W-1:0] MODE_PIXELS   = 16'd1016;
  localparam logic [MODE_W-1:0] MODE_ALT1047  = 16'd1047;
  localparam logic [MODE_W-1:0] MODE_SAVECUR  = 16'd1048;
  localparam logic [MODE_W-1:0] MODE_ALT1049  = 16'd1049;
  localparam logic [MODE_W-1:0] MODE_PASTE    = 16'd2004;

  typedef struct packed {
    logic [1:0]        operation;
    logic [MODE_W-1:0] mode_number;
    logic              enable;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        status;
    logic              save_cursor;
    logic              restore_cursor;
    logic              clear_screen;
    logic              clear_alternate;
    logic              home_for_origin;
    logic [FLAG_W-1:0] flags_now;
    logic [TRK_W-1:0]  mouse_tracking_now;
  } out_item_t;

  // decoded view of one mode number
  typedef struct packed {
    logic              ansi_hit;
    logic [FIDX_W-1:0] ansi_idx;
    trk_t              trk;
    logic              is_savecur;
    logic              priv_hit;
    logic [FIDX_W-1:0] priv_idx;
    logic              is_origin;
    logic              is_alt1047;
    logic              is_alt1049;
  } mode_dec_t;

endpackage

>>> src/tmrf_decode.sv
// ----------------------------------------------------------------------------
// tmrf_decode
// Maps a mode number onto its flag bit, tracking code and action class.
// ----------------------------------------------------------------------------
module tmrf_decode (
  input  logic [tmrf_pkg::MODE_W-1:0] mode_number,
  output tmrf_pkg::mode_dec_t         dec
);

  always_comb begin
    dec            = '0;
    dec.trk        = tmrf_pkg::TRK_OFF;
    dec.is_origin  = (mode_number == tmrf_pkg::MODE_ORIGIN);
    dec.is_alt1047 = (mode_number == tmrf_pkg::MODE_ALT1047);
    dec.is_alt1049 = (mode_number == tmrf_pkg::MODE_ALT1049);
    dec.is_savecur = (mode_number == tmrf_pkg::MODE_SAVECUR);

    unique case (mode_number)
      tmrf_pkg::MODE_INSERT: begin
        dec.ansi_hit = 1'b1;
        dec.ansi_idx = tmrf_pkg::FLAG_INSERT;
      end
      tmrf_pkg::MODE_NEWLINE: begin
        dec.ansi_hit = 1'b1;
        dec.ansi_idx = tmrf_pkg::FLAG_NEWLINE;
      end
      default: begin
        dec.ansi_hit = 1'b0;
        dec.ansi_idx = tmrf_pkg::FLAG_INSERT;
      end
    endcase

    unique case (mode_number)
      tmrf_pkg::MODE_TRK_X10:  dec.trk = tmrf_pkg::TRK_9;
      tmrf_pkg::MODE_TRK_1000: dec.trk = tmrf_pkg::TRK_1000;
      tmrf_pkg::MODE_TRK_1002: dec.trk = tmrf_pkg::TRK_1002;
      tmrf_pkg::MODE_TRK_1003: dec.trk = tmrf_pkg::TRK_1003;
      default:                 dec.trk = tmrf_pkg::TRK_OFF;
    endcase

    dec.priv_hit = 1'b1;
    unique case (mode_number)
      tmrf_pkg::MODE_APPKEYS: dec.priv_idx = tmrf_pkg::FLAG_APPKEYS;
      tmrf_pkg::MODE_ORIGIN:  dec.priv_idx = tmrf_pkg::FLAG_ORIGIN;
      tmrf_pkg::MODE_WRAP:    dec.priv_idx = tmrf_pkg::FLAG_WRAP;
      tmrf_pkg::MODE_BLINK:   dec.priv_idx = tmrf_pkg::FLAG_BLINK;
      tmrf_pkg::MODE_CURSOR:  dec.priv_idx = tmrf_pkg::FLAG_CURSOR;
      tmrf_pkg::MODE_ALT47:   dec.priv_idx = tmrf_pkg::FLAG_ALTSCR;
      tmrf_pkg::MODE_ALT1047: dec.priv_idx = tmrf_pkg::FLAG_ALTSCR;
      tmrf_pkg::MODE_ALT1049: dec.priv_idx = tmrf_pkg::FLAG_ALTSCR;
      tmrf_pkg::MODE_FOCUS:   dec.priv_idx = tmrf_pkg::FLAG_FOCUS;
      tmrf_pkg::MODE_UTF8:    dec.priv_idx = tmrf_pkg::FLAG_UTF8;
      tmrf_pkg::MODE_SGR:     dec.priv_idx = tmrf_pkg::FLAG_SGR;
      tmrf_pkg::MODE_ASCROLL: dec.priv_idx = tmrf_pkg::FLAG_ASCROLL;
      tmrf_pkg::MODE_URXVT:   dec.priv_idx = tmrf_pkg::FLAG_URXVT;
      tmrf_pkg::MODE_PIXELS:  dec.priv_idx = tmrf_pkg::FLAG_PIXELS;
      tmrf_pkg::MODE_PASTE:   dec.priv_idx = tmrf_pkg::FLAG_PASTE;
      default: begin
        dec.priv_hit = 1'b0;
        dec.priv_idx = tmrf_pkg::FLAG_INSERT;
      end
    endcase
  end

endmodule

>>> src/tmrf_core.sv
// ----------------------------------------------------------------------------
// tmrf_core
// Mode flag and mouse tracking state, with the update and query logic for
// one request. Outside reset, state moves only when step is high.
// ----------------------------------------------------------------------------
module tmrf_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  tmrf_pkg::in_item_t  item,
  output tmrf_pkg::out_item_t result
);

  logic [tmrf_pkg::FLAG_W-1:0] flags_r, flags_nxt;
  tmrf_pkg::trk_t              trk_r, trk_nxt;
  tmrf_pkg::mode_dec_t         dec;
  logic [tmrf_pkg::FLAG_W-1:0] wr_bit;

  function automatic logic [1:0] answer(input logic on);
    return on ? tmrf_pkg::STAT_SET : tmrf_pkg::STAT_RESET;
  endfunction

  tmrf_decode u_decode (
    .mode_number (item.mode_number),
    .dec         (dec)
  );

  always_comb begin
    flags_nxt = flags_r;
    trk_nxt   = trk_r;
    wr_bit    = '0;
    result    = '0;

    case (item.operation)
      tmrf_pkg::OP_SET_ANSI: begin
        if (dec.ansi_hit) begin
          flags_nxt[dec.ansi_idx] = item.enable;
        end
      end
      tmrf_pkg::OP_SET_PRIVATE: begin
        if (dec.trk != tmrf_pkg::TRK_OFF) begin
          if (item.enable) begin
            trk_nxt = dec.trk;
          end else if (trk_r == dec.trk) begin
            trk_nxt = tmrf_pkg::TRK_OFF;
          end
        end else if (dec.is_savecur) begin
          result.save_cursor    = item.enable;
          result.restore_cursor = !item.enable;
        end else if (dec.priv_hit) begin
          wr_bit[dec.priv_idx] = 1'b1;
          // turning one mouse encoding on drops the others
          if (item.enable && ((wr_bit & tmrf_pkg::ENCODING_MASK) != '0)) begin
            flags_nxt = flags_nxt & ~tmrf_pkg::ENCODING_MASK;
          end
          flags_nxt[dec.priv_idx] = item.enable;
          result.home_for_origin = dec.is_origin;
          result.clear_screen    = (dec.is_alt1047 || dec.is_alt1049) && item.enable;
          result.clear_alternate = (dec.is_alt1047 || dec.is_alt1049) && !item.enable;
          result.save_cursor     = dec.is_alt1049 && item.enable;
          result.restore_cursor  = dec.is_alt1049 && !item.enable;
        end
      end
      tmrf_pkg::OP_QRY_ANSI: begin
        if (dec.ansi_hit) begin
          result.status = answer(flags_r[dec.ansi_idx]);
        end
      end
      default: begin
        if (dec.trk != tmrf_pkg::TRK_OFF) begin
          result.status = answer(trk_r == dec.trk);
        end else if (dec.is_savecur) begin
          result.status = tmrf_pkg::STAT_RESET;
        end else if (dec.priv_hit) begin
          result.status = answer(flags_r[dec.priv_idx]);
        end
      end
    endcase

    result.flags_now          = flags_nxt;
    result.mouse_tracking_now = trk_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r <= '0;
      trk_r   <= tmrf_pkg::TRK_OFF;
    end else if (step) begin
      flags_r <= flags_nxt;
      trk_r   <= trk_nxt;
    end
  end

endmodule

>>> src/terminal_mode_register_file.sv
// ----------------------------------------------------------------------------
// terminal_mode_register_file
// Video terminal mode register set: ANSI and private mode set/reset with
// mode queries, one result per request.
//
//   channel | direction | payload                 | handshake
//   in_     | input     | tmrf_pkg::in_item_t     | in_valid / in_ready
//   out_    | output    | tmrf_pkg::out_item_t    | out_valid / out_ready
//
// A request is registered on acceptance, then decoded and applied to the mode
// state when it moves on, and its result is registered; throughput is one
// request per cycle while out_ready holds no result back.
// Reset clears all mode flags and turns mouse tracking off.
// A stalled result register holds the request stage; in_ready stays high
// as long as that stage can drain, so no bubble appears under back-pressure.
// ----------------------------------------------------------------------------
module terminal_mode_register_file (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  tmrf_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output tmrf_pkg::out_item_t out_data
);

  logic                s1_valid_r, s1_valid_nxt;
  tmrf_pkg::in_item_t  s1_item_r;
  logic                out_valid_r, out_valid_nxt;
  tmrf_pkg::out_item_t out_data_r;
  tmrf_pkg::out_item_t result;
  logic                step;
  logic                in_acc;

  assign step     = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || step;
  assign in_acc   = in_valid && in_ready;

  tmrf_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .item   (s1_item_r),
    .result (result)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (step) begin
      s1_valid_nxt = 1'b0;
    end

    out_valid_nxt = out_valid_r;
    if (step) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_item_r <= in_data;
    end
    if (step) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> src/tmrf_checker.sv
// ----------------------------------------------------------------------------
// tmrf_checker
// Port-level checks on the result channel of the mode register file.
// ----------------------------------------------------------------------------
module tmrf_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input tmrf_pkg::out_item_t out_data
);

  // a pending result is not withdrawn
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn before it was taken");

  // at most one mouse encoding is ever active
  a_enc_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $countones(out_data.flags_now & tmrf_pkg::ENCODING_MASK) <= 1)
    else $error("more than one mouse encoding active");

  // query answers never carry action requests
  a_qry_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != tmrf_pkg::STAT_UNKNOWN) |->
      !(out_data.save_cursor || out_data.restore_cursor || out_data.clear_screen ||
        out_data.clear_alternate || out_data.home_for_origin))
    else $error("action request on a query");

  // save and restore, clear and clear-alternate never together
  a_act_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.save_cursor && out_data.restore_cursor) &&
                  !(out_data.clear_screen && out_data.clear_alternate))
    else $error("conflicting cursor or screen requests");

  a_trk_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.mouse_tracking_now <= tmrf_pkg::TRK_1003)
    else $error("mouse tracking code out of range");

endmodule

bind terminal_mode_register_file tmrf_checker u_tmrf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
